// ----- sv/wcf_pkg.sv -----
package wcf_pkg;

   localparam int MaxRadius = 4;
   localparam int MaxWidth  = 1024;
   localparam int TapSlots  = 81;
   localparam int WinDim    = 9;
   localparam int LsRows    = 8;
   localparam int ColW      = 10;
   localparam int LsAddrW   = 13;
   localparam int TapW      = 7;

   // configuration register indexes
   localparam logic [2:0] REG_BYPASS = 3'd0;
   localparam logic [2:0] REG_MODE   = 3'd1;
   localparam logic [2:0] REG_RADIUS = 3'd2;
   localparam logic [2:0] REG_WIDTH  = 3'd3;
   localparam logic [2:0] REG_HEIGHT = 3'd4;
   localparam logic [2:0] REG_SCALE  = 3'd5;

   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_COEFF = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_LOAD,
      ST_MAC,
      ST_DRAIN,
      ST_SCALE,
      ST_ROUND,
      ST_OUT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic       capture;
      logic       fetch;
      logic       load;
      logic       mac_clear;
      logic       mac_step;
      logic       scale;
      logic       round;
      logic       out_load;
      logic [3:0] fetch_d;
      logic [3:0] mac_row;
      logic [3:0] mac_col;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic       is_coeff;
      logic       emit;
      logic       bypass;
      logic [3:0] k;
      logic [3:0] two_r;
   } status_type;

endpackage

// ----- sv/wcf_if.sv -----
interface wcf_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [7:0]  pixel;
   logic [6:0]  coeff_index;
   logic signed [15:0] coeff_value;
   modport source (output valid, cmd, pixel, coeff_index, coeff_value, input ready);
   modport sink (input valid, cmd, pixel, coeff_index, coeff_value, output ready);
endinterface

interface wcf_rsp_if;
   logic        valid;
   logic        ready;
   logic signed [15:0] out_value;
   logic        last;
   modport source (output valid, out_value, last, input ready);
   modport sink (input valid, out_value, last, output ready);
endinterface

interface wcf_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/wcf_ctrl.sv -----
module wcf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_fire,
   input  logic                 rsp_busy,
   input  wcf_pkg::status_type  status,
   output logic                 req_ready,
   output wcf_pkg::cmd_type     cmd
);

   wcf_pkg::state_type state_ff, state_in;
   logic [3:0] cnt_a_ff, cnt_a_in;
   logic [3:0] cnt_b_ff, cnt_b_in;

   // next state
   always_comb begin
      state_in = state_ff;
      cnt_a_in = cnt_a_ff;
      cnt_b_in = cnt_b_ff;
      unique case (state_ff)
         wcf_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = wcf_pkg::ST_FETCH;
               cnt_a_in = 4'd1;
            end
         end
         // the fetch state outlasts the last read so that its data lands before load
         wcf_pkg::ST_FETCH: begin
            if (status.is_coeff) begin
               state_in = wcf_pkg::ST_IDLE;
            end else if (cnt_a_ff > status.two_r) begin
               state_in = wcf_pkg::ST_LOAD;
            end else begin
               cnt_a_in = cnt_a_ff + 4'd1;
            end
         end
         wcf_pkg::ST_LOAD: begin
            cnt_a_in = '0;
            cnt_b_in = '0;
            if (!status.emit) state_in = wcf_pkg::ST_IDLE;
            else if (status.bypass) state_in = wcf_pkg::ST_OUT;
            else state_in = wcf_pkg::ST_MAC;
         end
         wcf_pkg::ST_MAC: begin
            if (cnt_b_ff == status.k - 4'd1) begin
               cnt_b_in = '0;
               if (cnt_a_ff == status.k - 4'd1) state_in = wcf_pkg::ST_DRAIN;
               else cnt_a_in = cnt_a_ff + 4'd1;
            end else begin
               cnt_b_in = cnt_b_ff + 4'd1;
            end
         end
         wcf_pkg::ST_DRAIN: state_in = wcf_pkg::ST_SCALE;
         wcf_pkg::ST_SCALE: state_in = wcf_pkg::ST_ROUND;
         wcf_pkg::ST_ROUND: state_in = wcf_pkg::ST_OUT;
         wcf_pkg::ST_OUT: begin
            if (!rsp_busy) state_in = wcf_pkg::ST_IDLE;
         end
         default: state_in = wcf_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      cmd.fetch_d = cnt_a_ff;
      cmd.mac_row = cnt_a_ff;
      cmd.mac_col = cnt_b_ff;
      unique case (state_ff)
         wcf_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.capture = req_fire;
         end
         wcf_pkg::ST_FETCH: cmd.fetch = (cnt_a_ff <= status.two_r);
         wcf_pkg::ST_LOAD: begin
            cmd.load = 1'b1;
            cmd.mac_clear = 1'b1;
         end
         wcf_pkg::ST_MAC: cmd.mac_step = 1'b1;
         wcf_pkg::ST_DRAIN: ;
         wcf_pkg::ST_SCALE: cmd.scale = 1'b1;
         wcf_pkg::ST_ROUND: cmd.round = 1'b1;
         wcf_pkg::ST_OUT: cmd.out_load = !rsp_busy;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wcf_pkg::ST_IDLE;
         cnt_a_ff <= '0;
         cnt_b_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_a_ff <= cnt_a_in;
         cnt_b_ff <= cnt_b_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == wcf_pkg::ST_IDLE) else $error("ready outside idle");
   a_fetch_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == wcf_pkg::ST_FETCH) else $error("accept not followed by fetch");
   a_mac_bounds: assert property (@(posedge clock) disable iff (reset)
      cmd.mac_step |-> cnt_a_ff < status.k && cnt_b_ff < status.k)
      else $error("tap counter out of window");
`endif

endmodule

// ----- sv/wcf_datapath.sv -----
module wcf_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  wcf_pkg::cmd_type     cmd,
   input  logic                 req_cmd,
   input  logic [7:0]           req_pixel,
   input  logic [6:0]           req_coeff_index,
   input  logic signed [15:0]   req_coeff_value,
   input  logic                 csr_we,
   input  logic [2:0]           csr_index,
   input  logic [15:0]          csr_data,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output logic signed [15:0]   rsp_out_value,
   output logic                 rsp_last,
   output wcf_pkg::status_type  status
);

   // configuration registers
   logic        bypass_ff, mode_ff;
   logic [2:0]  radius_ff;
   logic [10:0] width_ff;
   logic [15:0] height_ff, scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bypass_ff <= 1'b0;
         mode_ff   <= 1'b0;
         radius_ff <= 3'd1;
         width_ff  <= 11'd768;
         height_ff <= 16'd512;
         scale_ff  <= 16'd4096;
      end else if (csr_we) begin
         unique case (csr_index)
            wcf_pkg::REG_BYPASS: bypass_ff <= csr_data[0];
            wcf_pkg::REG_MODE:   mode_ff   <= csr_data[0];
            wcf_pkg::REG_RADIUS: radius_ff <= csr_data[2:0];
            wcf_pkg::REG_WIDTH:  width_ff  <= csr_data[10:0];
            wcf_pkg::REG_HEIGHT: height_ff <= csr_data;
            wcf_pkg::REG_SCALE:  scale_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // effective radius and width
   logic [2:0]  r_eff;
   logic [10:0] w_eff;
   logic [3:0]  two_r;
   always_comb begin
      if (radius_ff == 3'd0) r_eff = 3'd1;
      else if (radius_ff > 3'(wcf_pkg::MaxRadius)) r_eff = 3'(wcf_pkg::MaxRadius);
      else r_eff = radius_ff;
      if (width_ff == 11'd0) w_eff = 11'd1;
      else if (width_ff > 11'(wcf_pkg::MaxWidth)) w_eff = 11'(wcf_pkg::MaxWidth);
      else w_eff = width_ff;
      two_r = {r_eff, 1'b0};
   end

   // captured request
   logic        is_coeff_ff;
   logic [7:0]  px_ff;
   logic [6:0]  cidx_ff;
   logic signed [15:0] cval_ff;
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         is_coeff_ff <= req_cmd == wcf_pkg::CMD_COEFF;
         px_ff   <= req_pixel;
         cidx_ff <= req_coeff_index;
         cval_ff <= req_coeff_value;
      end
   end

   // counters
   logic [15:0] row_ff;
   logic [10:0] colc_ff;
   logic [9:0]  col;
   assign col = (colc_ff < 11'(wcf_pkg::MaxWidth)) ? colc_ff[9:0]
                                                     : 10'(wcf_pkg::MaxWidth - 1);
   logic row_end, last_c, emit_c;
   assign row_end = (colc_ff + 11'd1) >= w_eff;
   assign last_c  = (row_ff == height_ff - 16'd1) && row_end;
   assign emit_c  = bypass_ff || (row_ff >= 16'(two_r) && colc_ff >= 11'(two_r));

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff  <= '0;
         colc_ff <= '0;
      end else if (cmd.load) begin
         if (row_end) begin
            colc_ff <= '0;
            row_ff  <= last_c ? 16'd0 : row_ff + 16'd1;
         end else begin
            colc_ff <= colc_ff + 11'd1;
         end
      end
   end

   // coefficient table with valid bits
   logic signed [15:0] coeff_mem [wcf_pkg::TapSlots];
   logic [wcf_pkg::TapSlots-1:0] coeff_vld_ff;
   logic [6:0] tap_addr;
   logic signed [15:0] coeff_rd_ff;
   logic coeff_rd_vld_ff;
   assign tap_addr = 7'(cmd.mac_row * 4'd9) + 7'(cmd.mac_col);
   always_ff @(posedge clock) begin
      if (reset) coeff_vld_ff <= '0;
      else if (cmd.fetch && is_coeff_ff && cidx_ff < 7'(wcf_pkg::TapSlots))
         coeff_vld_ff[cidx_ff] <= 1'b1;
   end
   always_ff @(posedge clock) begin
      if (cmd.fetch && is_coeff_ff && cidx_ff < 7'(wcf_pkg::TapSlots))
         coeff_mem[cidx_ff] <= cval_ff;
      coeff_rd_ff     <= coeff_mem[tap_addr];
      coeff_rd_vld_ff <= coeff_vld_ff[tap_addr];
   end

   // line store: read one older row per fetch cycle, write on load
   logic [7:0] ls_mem [1 << wcf_pkg::LsAddrW];
   logic [7:0] ls_rd_ff;
   logic [2:0] rd_row;
   logic [3:0] fd_dly_ff;
   logic       fetch_dly_ff;
   assign rd_row = row_ff[2:0] - cmd.fetch_d[2:0];
   always_ff @(posedge clock) begin
      if (cmd.load) ls_mem[{row_ff[2:0], col}] <= px_ff;
      ls_rd_ff     <= ls_mem[{rd_row, col}];
      fd_dly_ff    <= cmd.fetch_d;
      fetch_dly_ff <= cmd.fetch && !is_coeff_ff;
   end

   // new column, gathered as reads return
   logic [7:0] newcol_ff [wcf_pkg::WinDim];
   always_ff @(posedge clock) begin
      if (fetch_dly_ff) newcol_ff[4'd8 - fd_dly_ff] <= ls_rd_ff;
   end

   // window shift; column 8 is the newest
   logic [7:0] win_ff [wcf_pkg::WinDim][wcf_pkg::WinDim];
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         for (int rr = 0; rr < wcf_pkg::WinDim; rr++) begin
            for (int cc = 0; cc < wcf_pkg::WinDim - 1; cc++)
               win_ff[rr][cc] <= win_ff[rr][cc+1];
            if (rr == wcf_pkg::WinDim - 1) win_ff[rr][8] <= px_ff;
            else if (4'(8 - rr) <= two_r) win_ff[rr][8] <= newcol_ff[rr];
            else win_ff[rr][8] <= 8'd0;
         end
      end
   end

   // tap pixel select, registered alongside coefficient read
   logic [3:0] k;
   logic [3:0] wr_sel, wc_sel;
   logic [7:0] tap_px_ff;
   logic       mac_dly_ff;
   assign k = two_r + 4'd1;
   assign wr_sel = 4'd9 - k + cmd.mac_row;
   assign wc_sel = 4'd9 - k + cmd.mac_col;
   always_ff @(posedge clock) begin
      tap_px_ff  <= win_ff[wr_sel][wc_sel];
      mac_dly_ff <= cmd.mac_step;
   end

   // accumulate, scale, round
   logic signed [31:0] acc_ff;
   logic signed [48:0] prod_ff;
   logic               last_ff, bypass_res_ff;
   logic signed [15:0] res_ff;
   logic signed [24:0] term;
   assign term = $signed({1'b0, tap_px_ff}) * (coeff_rd_vld_ff ? coeff_rd_ff : 16'sd0);
   always_ff @(posedge clock) begin
      if (cmd.mac_clear) begin
         acc_ff        <= '0;
         last_ff       <= last_c;
         bypass_res_ff <= bypass_ff;
      end else if (mac_dly_ff) begin
         acc_ff <= acc_ff + 32'(term);
      end
      if (cmd.scale) prod_ff <= acc_ff * $signed({1'b0, scale_ff});
   end

   logic signed [48:0] sh27, sh20;
   always_comb begin
      sh27 = prod_ff >>> 27;
      sh20 = prod_ff >>> 20;
   end
   always_ff @(posedge clock) begin
      if (cmd.round) begin
         if (!mode_ff) begin
            if (sh27 < 0) res_ff <= 16'sd0;
            else if (sh27 > 49'sd255) res_ff <= 16'sd255;
            else res_ff <= 16'(sh27);
         end else begin
            if (sh20 > 49'sd32767) res_ff <= 16'sd32767;
            else if (sh20 < -49'sd32768) res_ff <= -16'sd32768;
            else res_ff <= 16'(sh20);
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else if (cmd.out_load) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
   end
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_out_value <= bypass_res_ff ? $signed({8'd0, px_ff}) : res_ff;
         rsp_last      <= last_ff;
      end
   end

   assign status.is_coeff = is_coeff_ff;
   assign status.emit     = emit_c;
   assign status.bypass   = bypass_ff;
   assign status.k        = k;
   assign status.two_r    = two_r;

`ifndef NO_ASSERTIONS
   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("result dropped");
   a_col_bound: assert property (@(posedge clock) disable iff (reset)
      colc_ff <= 11'(wcf_pkg::MaxWidth)) else $error("column beyond width");
   a_mode0_range: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.round) && !mode_ff |-> res_ff >= 0 && res_ff <= 16'sd255)
      else $error("mode 0 result out of range");
`endif

endmodule

// ----- sv/window_convolution_filter_core.sv -----
// channel  role   payload
// req      sink   cmd, pixel, coeff_index, coeff_value
// rsp      source out_value, last
// csr      sink   index, data
// a pixel passes idle, fetch and load; with a result it goes on to out, via mac, drain, scale, round unless bypassed
// the tap loop of the single multiply-accumulate unit sets the pixel time
// a coefficient write passes through the fetch state and returns to idle
// reset is synchronous, active high; csr is always ready
// a waiting result holds the controller in its output state
module window_convolution_filter_core (
   input logic     clock,
   input logic     reset,
   wcf_req_if.sink req,
   wcf_rsp_if.source rsp,
   wcf_csr_if.sink csr
);

   wcf_pkg::cmd_type    cmd;
   wcf_pkg::status_type status;
   logic req_fire;

   assign csr.ready = 1'b1;
   assign req_fire  = req.valid && req.ready;

   wcf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .rsp_busy  (rsp.valid && !rsp.ready),
      .status    (status),
      .req_ready (req.ready),
      .cmd       (cmd)
   );

   wcf_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_cmd         (req.cmd),
      .req_pixel       (req.pixel),
      .req_coeff_index (req.coeff_index),
      .req_coeff_value (req.coeff_value),
      .csr_we          (csr.valid),
      .csr_index       (csr.index),
      .csr_data        (csr.data),
      .rsp_ready       (rsp.ready),
      .rsp_valid       (rsp.valid),
      .rsp_out_value   (rsp.out_value),
      .rsp_last        (rsp.last),
      .status          (status)
   );

endmodule

// ----- dv/tb_window_convolution_filter_core.sv -----
`timescale 1ns / 100ps

module tb_window_convolution_filter_core;

   typedef struct packed {
      logic        cmd;
      logic [7:0]  pixel;
      logic [6:0]  coeff_index;
      logic [15:0] coeff_value;
   } pix_req_type;

   typedef struct packed {
      logic [15:0] out_value;
      logic        last;
   } pix_rsp_type;

   // stimulus entry: either a request or a register write
   typedef struct packed {
      logic        is_csr;
      logic [2:0]  csr_index;
      logic [15:0] csr_data;
      pix_req_type req;
   } stim_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   wcf_req_if req_ch();
   wcf_rsp_if rsp_ch();
   wcf_csr_if csr_ch();

   window_convolution_filter_core dut (
      .clock(clock), .reset(reset), .req(req_ch.sink), .rsp(rsp_ch.source), .csr(csr_ch.sink)
   );

   always #4 clock = ~clock;

   // predictor state
   logic        cfg_bypass;
   logic        cfg_mode;
   logic [2:0]  cfg_radius;
   logic [10:0] cfg_width;
   logic [15:0] cfg_height;
   logic [15:0] cfg_scale;
   logic [7:0]  line_mem [wcf_pkg::LsRows*wcf_pkg::MaxWidth];
   logic [7:0]  win [wcf_pkg::WinDim][wcf_pkg::WinDim];
   logic signed [15:0] taps [wcf_pkg::TapSlots];
   logic [15:0] row_cnt;
   int unsigned col_cnt;

   stim_type    pending_q[$];
   pix_rsp_type filtered_q[$];
   int       n_err = 0;
   bit       hold_sender = 0;
   bit       drained = 0;
   bit       req_taken = 0;
   bit       csr_taken = 0;

   function automatic void predict_reset();
      cfg_bypass = 0; cfg_mode = 0; cfg_radius = 1; cfg_width = 768;
      cfg_height = 512; cfg_scale = 4096;
      foreach (line_mem[i]) line_mem[i] = '0;
      foreach (win[i, j]) win[i][j] = '0;
      foreach (taps[i]) taps[i] = '0;
      row_cnt = 0; col_cnt = 0;
   endfunction

   function automatic void predict_csr(logic [2:0] idx, logic [15:0] d);
      case (idx)
         wcf_pkg::REG_BYPASS: cfg_bypass = d[0];
         wcf_pkg::REG_MODE:   cfg_mode   = d[0];
         wcf_pkg::REG_RADIUS: cfg_radius = d[2:0];
         wcf_pkg::REG_WIDTH:  cfg_width  = d[10:0];
         wcf_pkg::REG_HEIGHT: cfg_height = d;
         wcf_pkg::REG_SCALE:  cfg_scale  = d;
         default: ;
      endcase
   endfunction

   // window filter prediction for one accepted request
   function automatic void predict_filter(pix_req_type r);
      int unsigned rad, w, row, col, k;
      longint sum, v;
      logic lst, emit;
      logic [15:0] res;
      if (r.cmd == wcf_pkg::CMD_COEFF) begin
         if (r.coeff_index < wcf_pkg::TapSlots) taps[r.coeff_index] = r.coeff_value;
         return;
      end
      rad = cfg_radius == 0 ? 1 :
            (cfg_radius > wcf_pkg::MaxRadius ? wcf_pkg::MaxRadius : cfg_radius);
      w = cfg_width == 0 ? 1 :
          (cfg_width > wcf_pkg::MaxWidth ? wcf_pkg::MaxWidth : cfg_width);
      row = row_cnt;
      col = col_cnt < wcf_pkg::MaxWidth ? col_cnt : wcf_pkg::MaxWidth - 1;
      for (int rr = 0; rr < wcf_pkg::WinDim; rr++) begin
         for (int cc = 0; cc < wcf_pkg::WinDim - 1; cc++) win[rr][cc] = win[rr][cc+1];
         win[rr][wcf_pkg::WinDim-1] = '0;
      end
      win[wcf_pkg::WinDim-1][wcf_pkg::WinDim-1] = r.pixel;
      for (int d = 1; d <= 2*rad; d++)
         win[wcf_pkg::WinDim-1-d][wcf_pkg::WinDim-1] =
            line_mem[((row + wcf_pkg::LsRows - d) % wcf_pkg::LsRows)*wcf_pkg::MaxWidth + col];
      line_mem[(row % wcf_pkg::LsRows)*wcf_pkg::MaxWidth + col] = r.pixel;
      lst = (row == ((cfg_height + 16'hFFFF) & 16'hFFFF)) && (col_cnt + 1 >= w);
      emit = cfg_bypass ? 1'b1 : (row >= 2*rad && col_cnt >= 2*rad);
      res = '0;
      if (cfg_bypass) res = 16'(r.pixel);
      else if (emit) begin
         k = 2*rad + 1;
         sum = 0;
         for (int rr = 0; rr < k; rr++)
            for (int cc = 0; cc < k; cc++)
               sum += longint'(win[wcf_pkg::WinDim-k+rr][wcf_pkg::WinDim-k+cc]) *
                      longint'(taps[rr*9+cc]);
         sum *= longint'(cfg_scale);
         if (cfg_mode == 0) begin
            v = sum >>> 27;
            res = v < 0 ? 16'd0 : (v > 255 ? 16'd255 : v[15:0]);
         end else begin
            v = sum >>> 20;
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            res = v[15:0];
         end
      end
      if (col_cnt + 1 >= w) begin
         col_cnt = 0;
         row_cnt = lst ? 16'd0 : 16'(row + 1);
      end else col_cnt++;
      if (emit) filtered_q.push_back('{out_value: res, last: lst});
   endfunction

   // receiver stall pattern changes every so often
   int stall_mode = 0, stall_cnt = 0;
   int idle_wait = 0;
   always @(negedge clock) begin
      if (stall_cnt == 0) begin
         stall_mode <= $urandom_range(0, 1);
         stall_cnt  <= $urandom_range(50, 400);
      end else stall_cnt <= stall_cnt - 1;
   end

   // driver: bursts and gaps, csr writes only when idle
   int burst_left = 0, gap_left = 0;
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid       <= 1'b0;
         req_ch.cmd         <= 1'b0;
         req_ch.pixel       <= '0;
         req_ch.coeff_index <= '0;
         req_ch.coeff_value <= '0;
         csr_ch.valid       <= 1'b0;
         csr_ch.index       <= '0;
         csr_ch.data        <= '0;
         rsp_ch.ready       <= 1'b0;
      end else begin
         if (csr_taken) csr_ch.valid <= 0;
         else if (req_taken) req_ch.valid <= 0;
         else if (!req_ch.valid && !csr_ch.valid && !hold_sender && pending_q.size() > 0) begin
            if (pending_q[0].is_csr) begin
               if (filtered_q.size() == 0 && idle_wait == 0) begin
                  csr_ch.index <= pending_q[0].csr_index;
                  csr_ch.data  <= pending_q[0].csr_data;
                  csr_ch.valid <= 1;
               end
            end else if (gap_left > 0) gap_left--;
            else begin
               req_ch.cmd         <= pending_q[0].req.cmd;
               req_ch.pixel       <= pending_q[0].req.pixel;
               req_ch.coeff_index <= pending_q[0].req.coeff_index;
               req_ch.coeff_value <= pending_q[0].req.coeff_value;
               req_ch.valid <= 1;
               if (burst_left > 0) burst_left--;
               else begin
                  burst_left = $urandom_range(0, 30);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end
            end
         end
         rsp_ch.ready <= (stall_mode == 0) ? 1'b1 : ($urandom_range(0, 3) != 0);
      end
   end

   // settle time before register writes, covering result-less pixels still in flight
   always @(posedge clock) begin
      req_taken <= req_ch.valid && req_ch.ready;
      csr_taken <= csr_ch.valid && csr_ch.ready;
      if (req_ch.valid && req_ch.ready) idle_wait <= 120;
      else if (idle_wait > 0) idle_wait <= idle_wait - 1;
   end

   // monitor: predict on accepted requests, check accepted results
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_ch.valid && csr_ch.ready) begin
            predict_csr(csr_ch.index, csr_ch.data);
            void'(pending_q.pop_front());
         end
         if (req_ch.valid && req_ch.ready) begin
            predict_filter(pending_q[0].req);
            void'(pending_q.pop_front());
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (filtered_q.size() == 0) begin
               n_err++;
               if (n_err <= 10) $display("unexpected result %h last %b",
                                         rsp_ch.out_value, rsp_ch.last);
            end else begin
               if (rsp_ch.out_value !== filtered_q[0].out_value ||
                   rsp_ch.last !== filtered_q[0].last) begin
                  n_err++;
                  if (n_err <= 10)
                     $display("mismatch: expected %h/%b got %h/%b",
                              filtered_q[0].out_value, filtered_q[0].last,
                              rsp_ch.out_value, rsp_ch.last);
               end
               void'(filtered_q.pop_front());
            end
         end
      end
   end

   function automatic stim_type pix(logic [7:0] p);
      stim_type s;
      s = '0;
      s.req.cmd = wcf_pkg::CMD_PIXEL;
      s.req.pixel = p;
      s.req.coeff_index = 7'($urandom_range(0, 127));
      s.req.coeff_value = 16'($urandom);
      return s;
   endfunction

   function automatic stim_type coeff(logic [6:0] idx, logic [15:0] val);
      stim_type s;
      s = '0;
      s.req.cmd = wcf_pkg::CMD_COEFF;
      s.req.pixel = 8'($urandom);
      s.req.coeff_index = idx;
      s.req.coeff_value = val;
      return s;
   endfunction

   function automatic stim_type reg_wr(logic [2:0] idx, logic [15:0] d);
      stim_type s;
      s = '0;
      s.is_csr = 1;
      s.csr_index = idx;
      s.csr_data = d;
      return s;
   endfunction

   // one whole plane with random pixels, optionally a random table first
   task automatic add_plane(int w, int h, int rad, bit mode, bit byp, int scale, bit rnd_taps);
      pending_q.push_back(reg_wr(wcf_pkg::REG_BYPASS, 16'(byp)));
      pending_q.push_back(reg_wr(wcf_pkg::REG_MODE, 16'(mode)));
      pending_q.push_back(reg_wr(wcf_pkg::REG_RADIUS, 16'(rad)));
      pending_q.push_back(reg_wr(wcf_pkg::REG_WIDTH, 16'(w)));
      pending_q.push_back(reg_wr(wcf_pkg::REG_HEIGHT, 16'(h)));
      pending_q.push_back(reg_wr(wcf_pkg::REG_SCALE, 16'(scale)));
      if (rnd_taps)
         repeat ($urandom_range(3, 20))
            pending_q.push_back(coeff(7'($urandom_range(0, 127)), 16'($urandom)));
      for (int i = 0; i < w*h; i++) begin
         case ($urandom_range(0, 5))
            0: pending_q.push_back(pix(8'h00));
            1: pending_q.push_back(pix(8'hFF));
            default: pending_q.push_back(pix(8'($urandom)));
         endcase
      end
   endtask

   int items;
   initial begin
      predict_reset();
      // directed: extreme taps, out-of-table index, bypass, smallest planes
      pending_q.push_back(coeff(7'd0, 16'h7FFF));
      pending_q.push_back(coeff(7'd80, 16'h8000));
      pending_q.push_back(coeff(7'd127, 16'h1234));
      pending_q.push_back(coeff(7'd4, 16'h7FFF));
      add_plane(3, 3, 1, 0, 1, 65535, 0);
      add_plane(3, 3, 1, 1, 0, 65535, 0);
      add_plane(2, 4, 1, 0, 0, 4096, 0);
      hold_sender = 0;
      repeat (3) @(posedge clock);
      reset <= 0;
      // random: mostly small planes, a few with radius 4 and extreme scales
      items = 0;
      while (items < 900) begin
         int w, h, rad;
         rad = $urandom_range(1, 4);
         w = $urandom_range(2*rad + 1, 2*rad + 6);
         h = $urandom_range(2*rad + 1, 2*rad + 4);
         if ($urandom_range(0, 9) == 0) h = $urandom_range(1, 2*rad);
         add_plane(w, h, rad, 1'($urandom_range(0, 1)), $urandom_range(0, 7) == 0,
                   ($urandom_range(0, 3) == 0) ? 65535 :
                   (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 65535)), 1);
         items += w*h;
         if (items > 800 && !drained) begin
            // let the block drain completely before continuing
            drained = 1;
            wait (pending_q.size() == 0);
            hold_sender = 1;
            wait (filtered_q.size() == 0);
            hold_sender = 0;
         end
      end
      add_plane(256, 3, 1, 1, 0, 65535, 1);
      wait (pending_q.size() == 0);
      wait (filtered_q.size() == 0);
      repeat (200) @(posedge clock);
      if (n_err == 0 && filtered_q.size() == 0)
         $display("[window_convolution_filter_core] OK");
      else
         $display("[window_convolution_filter_core] ERROR");
      $finish;
   end

   initial begin
      #250ms;
      $display("[window_convolution_filter_core] ERROR");
      $finish;
   end

endmodule
